@@ design/csc_pkg.sv @@
package csc_pkg;

	// Fixed widths of the item fields and the register port.
	localparam int OP_W         = 2;
	localparam int COORD_W      = 8;
	localparam int VALUE_PORT_W = 32;
	localparam int STATUS_W     = 3;
	localparam int CFG_W        = 9;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;

	// Largest dimension that a nine-bit register can ask for.
	localparam int REG_DIM_MAX = 511;

	// Register indexes, taken from the word address bit.
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_SCAN   = 2'd1,
		OP_COORD  = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_NOMAT = 3'd1,
		ST_RANGE = 3'd2,
		ST_FULL  = 3'd3,
		ST_ORDER = 3'd4
	} status_t;

	// Classification of one item, as the front hands it to the back.
	typedef struct packed {
		op_t  op;
		logic range_err;
		logic nonzero;
	} cmd_ctl_t;

	typedef enum logic [2:0] {
		BE_IDLE,
		BE_EXEC,
		BE_FILL,
		BE_COMMIT,
		BE_START,
		BE_END,
		BE_WALK
	} be_state_t;

endpackage

@@ design/csc_front.sv @@
module csc_front #(
	parameter int DIM_DEPTH = 256,
	parameter int VAL_W = 32,
	localparam int DIM_W = $clog2(DIM_DEPTH + 1),
	localparam int IDX_W = $clog2(DIM_DEPTH),
	localparam int DATA_W = VAL_W + 2 * IDX_W
) (
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [csc_pkg::OP_W-1:0]             op,
	input  logic signed [csc_pkg::VALUE_PORT_W-1:0] value,
	input  logic [csc_pkg::COORD_W-1:0]          row,
	input  logic [csc_pkg::COORD_W-1:0]          col,
	input  logic [DIM_W-1:0]                     rows,
	input  logic [DIM_W-1:0]                     cols,
	input  logic                                 q_full,
	output logic                                 push,
	output csc_pkg::cmd_ctl_t                    push_ctl,
	output logic [DATA_W-1:0]                    push_data
);
	import csc_pkg::*;

	localparam int CMP_W = (DIM_W > COORD_W) ? DIM_W : COORD_W;

	// An item is taken whenever the queue has room.
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Decode the operation, check the coordinates and flag a zero value.
	always_comb begin
		push_ctl.op        = op_t'(op);
		push_ctl.range_err = (CMP_W'(row) >= CMP_W'(rows)) || (CMP_W'(col) >= CMP_W'(cols));
		push_ctl.nonzero   = |value[VAL_W-1:0];
		push_data          = {value[VAL_W-1:0], IDX_W'(row), IDX_W'(col)};
	end

endmodule

@@ design/csc_cmd_fifo.sv @@
module csc_cmd_fifo #(
	parameter int DATA_W = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  csc_pkg::cmd_ctl_t push_ctl,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output csc_pkg::cmd_ctl_t head_ctl,
	output logic [DATA_W-1:0] head_data
);
	import csc_pkg::*;

	cmd_ctl_t          ctl_q [2];
	logic [DATA_W-1:0] data_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_ctl   = ctl_q[rd_ptr_q];
	assign head_data  = data_q[rd_ptr_q];

	// Two-entry ring of classified items.
	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]  <= push_ctl;
			data_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ design/csc_back.sv @@
module csc_back #(
	parameter int MAX_ENTRIES = 1024,
	parameter int DIM_DEPTH = 256,
	parameter int VAL_W = 32,
	localparam int DIM_W = $clog2(DIM_DEPTH + 1),
	localparam int IDX_W = $clog2(DIM_DEPTH),
	localparam int DATA_W = VAL_W + 2 * IDX_W
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [DIM_W-1:0]                      rows,
	input  logic [DIM_W-1:0]                      cols,
	input  logic                                  head_valid,
	input  csc_pkg::cmd_ctl_t                     head_ctl,
	input  logic [DATA_W-1:0]                     head_data,
	output logic                                  pop,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [csc_pkg::VALUE_PORT_W-1:0] value_out,
	output logic [csc_pkg::STATUS_W-1:0]          status
);
	import csc_pkg::*;

	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int ADDR_W = $clog2(MAX_ENTRIES);

	// Entry and column stores.
	logic [VAL_W-1:0] value_mem [MAX_ENTRIES];
	logic [IDX_W-1:0] row_mem [MAX_ENTRIES];
	logic [CNT_W-1:0] cs_mem [DIM_DEPTH];

	be_state_t        state_q, state_d;
	cmd_ctl_t         cur_ctl_q;
	logic [VAL_W-1:0] cur_val_q;
	logic [IDX_W-1:0] cur_row_q;
	logic [IDX_W-1:0] cur_col_q;

	logic [CNT_W-1:0] entry_count_q;
	logic [IDX_W-1:0] last_col_q;
	logic [IDX_W-1:0] scan_row_q;
	logic [DIM_W-1:0] scan_col_q;
	logic             loaded_q;

	logic [IDX_W-1:0] fill_col_q;
	logic [CNT_W-1:0] start_q;
	logic [CNT_W-1:0] end_q;
	logic [CNT_W-1:0] walk_idx_q;
	logic             rd_pend_q;
	logic [CNT_W-1:0] cs_rd_q;
	logic [VAL_W-1:0] val_rd_q;
	logic [IDX_W-1:0] row_rd_q;

	logic                    out_valid_q;
	logic [VALUE_PORT_W-1:0] out_value_q;
	status_t                 out_status_q;

	// Derived conditions.
	logic             out_free;
	logic [IDX_W-1:0] store_row;
	logic [IDX_W-1:0] store_col;
	logic             scan_done;
	logic             order_err;
	logic             store_full;
	logic             need_fill;
	logic             row_match;
	logic             walk_more;
	logic [DIM_W:0]   row_inc;
	logic             row_wrap;

	// Decision for the item under execution.
	logic    ex_finish;
	status_t ex_status;
	logic    ex_clear;
	logic    ex_scan_zero;
	logic    ex_store;
	logic    ex_lookup;

	// Control strobes.
	logic                    emit;
	status_t                 emit_status;
	logic [VALUE_PORT_W-1:0] emit_value;
	logic                    do_clear;
	logic                    do_commit;
	logic                    do_scan_adv;
	logic                    set_loaded;
	logic                    fill_init;
	logic                    fill_we;
	logic                    cs_rd_en;
	logic [IDX_W-1:0]        cs_rd_addr;
	logic                    cap_start;
	logic                    cap_end;
	logic                    walk_issue;

	assign out_free   = !out_valid_q || out_ready;
	assign store_row  = (cur_ctl_q.op == OP_SCAN) ? scan_row_q : cur_row_q;
	assign store_col  = (cur_ctl_q.op == OP_SCAN) ? IDX_W'(scan_col_q) : cur_col_q;
	assign scan_done  = (scan_col_q >= cols);
	assign order_err  = (entry_count_q != '0) && (store_col < last_col_q);
	assign store_full = (entry_count_q == CNT_W'(MAX_ENTRIES));
	assign need_fill  = (store_col > last_col_q);
	assign row_match  = rd_pend_q && (row_rd_q == cur_row_q);
	assign walk_more  = (walk_idx_q < end_q);
	assign row_inc    = (DIM_W + 1)'(scan_row_q) + (DIM_W + 1)'(1);
	assign row_wrap   = (row_inc >= (DIM_W + 1)'(rows));

	// Classify the item in hand against the matrix state.
	always_comb begin
		ex_finish    = 1'b0;
		ex_status    = ST_OK;
		ex_clear     = 1'b0;
		ex_scan_zero = 1'b0;
		ex_store     = 1'b0;
		ex_lookup    = 1'b0;
		unique case (cur_ctl_q.op)
			OP_CLEAR: begin
				ex_finish = 1'b1;
				ex_clear  = 1'b1;
			end
			OP_SCAN: begin
				if (scan_done) begin
					ex_finish = 1'b1;
					ex_status = ST_RANGE;
				end else if (!cur_ctl_q.nonzero) begin
					ex_finish    = 1'b1;
					ex_scan_zero = 1'b1;
				end else begin
					ex_store = 1'b1;
				end
			end
			OP_COORD: begin
				if (cur_ctl_q.range_err) begin
					ex_finish = 1'b1;
					ex_status = ST_RANGE;
				end else begin
					ex_store = 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (!loaded_q) begin
					ex_finish = 1'b1;
					ex_status = ST_NOMAT;
				end else if (cur_ctl_q.range_err) begin
					ex_finish = 1'b1;
					ex_status = ST_RANGE;
				end else begin
					ex_lookup = 1'b1;
				end
			end
		endcase
		if (ex_store && order_err) begin
			ex_store  = 1'b0;
			ex_finish = 1'b1;
			ex_status = ST_ORDER;
		end else if (ex_store && store_full) begin
			ex_store  = 1'b0;
			ex_finish = 1'b1;
			ex_status = ST_FULL;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BE_IDLE: begin
				if (head_valid) begin
					state_d = BE_EXEC;
				end
			end
			BE_EXEC: begin
				if (ex_finish) begin
					if (out_free) begin
						state_d = BE_IDLE;
					end
				end else if (ex_store) begin
					state_d = need_fill ? BE_FILL : BE_COMMIT;
				end else if (ex_lookup) begin
					state_d = BE_START;
				end
			end
			BE_FILL: begin
				if (fill_col_q == store_col) begin
					state_d = BE_COMMIT;
				end
			end
			BE_COMMIT: begin
				if (out_free) begin
					state_d = BE_IDLE;
				end
			end
			BE_START: state_d = BE_END;
			BE_END:   state_d = BE_WALK;
			BE_WALK: begin
				if ((row_match || !walk_more) && out_free) begin
					state_d = BE_IDLE;
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	// Strobes for each state.
	always_comb begin
		pop         = 1'b0;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_value  = '0;
		do_clear    = 1'b0;
		do_commit   = 1'b0;
		do_scan_adv = 1'b0;
		set_loaded  = 1'b0;
		fill_init   = 1'b0;
		fill_we     = 1'b0;
		cs_rd_en    = 1'b0;
		cs_rd_addr  = cur_col_q;
		cap_start   = 1'b0;
		cap_end     = 1'b0;
		walk_issue  = 1'b0;
		unique case (state_q)
			BE_IDLE: begin
				pop = head_valid;
			end
			BE_EXEC: begin
				if (ex_finish && out_free) begin
					emit        = 1'b1;
					emit_status = ex_status;
					do_clear    = ex_clear;
					do_scan_adv = ex_scan_zero;
					set_loaded  = ex_scan_zero;
				end
				fill_init = ex_store && need_fill;
				cs_rd_en  = ex_lookup;
			end
			BE_FILL: begin
				fill_we = 1'b1;
			end
			BE_COMMIT: begin
				if (out_free) begin
					emit        = 1'b1;
					do_commit   = 1'b1;
					set_loaded  = 1'b1;
					do_scan_adv = (cur_ctl_q.op == OP_SCAN);
				end
			end
			BE_START: begin
				cap_start  = 1'b1;
				cs_rd_en   = 1'b1;
				cs_rd_addr = cur_col_q + IDX_W'(1);
			end
			BE_END: begin
				cap_end = 1'b1;
			end
			BE_WALK: begin
				if (row_match) begin
					emit       = out_free;
					emit_value = VALUE_PORT_W'(signed'(val_rd_q));
				end else if (walk_more) begin
					walk_issue = 1'b1;
				end else begin
					emit = out_free;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// State register and matrix bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BE_IDLE;
			entry_count_q <= '0;
			last_col_q    <= '0;
			scan_row_q    <= '0;
			scan_col_q    <= '0;
			loaded_q      <= 1'b0;
			rd_pend_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_clear) begin
				entry_count_q <= '0;
				last_col_q    <= '0;
				scan_row_q    <= '0;
				scan_col_q    <= '0;
				loaded_q      <= 1'b0;
			end
			if (do_commit) begin
				entry_count_q <= entry_count_q + CNT_W'(1);
				last_col_q    <= store_col;
			end
			if (set_loaded) begin
				loaded_q <= 1'b1;
			end
			if (do_scan_adv) begin
				if (row_wrap) begin
					scan_row_q <= '0;
					scan_col_q <= scan_col_q + DIM_W'(1);
				end else begin
					scan_row_q <= IDX_W'(row_inc);
				end
			end
			if (cap_end) begin
				rd_pend_q <= 1'b0;
			end else if (walk_issue) begin
				rd_pend_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item in hand, walk bounds and result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_ctl_q <= head_ctl;
			cur_val_q <= head_data[DATA_W-1 -: VAL_W];
			cur_row_q <= head_data[2*IDX_W-1 -: IDX_W];
			cur_col_q <= head_data[IDX_W-1:0];
		end
		if (fill_init) begin
			fill_col_q <= last_col_q + IDX_W'(1);
		end else if (fill_we) begin
			fill_col_q <= fill_col_q + IDX_W'(1);
		end
		if (cap_start) begin
			if ((entry_count_q != '0) && (cur_col_q <= last_col_q)) begin
				start_q <= (cur_col_q == '0) ? '0 : cs_rd_q;
			end else begin
				start_q <= entry_count_q;
			end
		end
		if (cap_end) begin
			if ((entry_count_q != '0) && (cur_col_q < last_col_q)) begin
				end_q <= cs_rd_q;
			end else begin
				end_q <= entry_count_q;
			end
			walk_idx_q <= start_q;
		end else if (walk_issue) begin
			walk_idx_q <= walk_idx_q + CNT_W'(1);
		end
		if (emit) begin
			out_value_q  <= emit_value;
			out_status_q <= emit_status;
		end
	end

	// Entry store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (do_commit) begin
			value_mem[entry_count_q[ADDR_W-1:0]] <= cur_val_q;
			row_mem[entry_count_q[ADDR_W-1:0]]   <= store_row;
		end
		if (walk_issue) begin
			val_rd_q <= value_mem[walk_idx_q[ADDR_W-1:0]];
			row_rd_q <= row_mem[walk_idx_q[ADDR_W-1:0]];
		end
	end

	// Column start store: filled for each column from the one after the last stored column up to a new entry's column.
	always_ff @(posedge clk) begin
		if (fill_we) begin
			cs_mem[fill_col_q] <= entry_count_q;
		end
		if (cs_rd_en) begin
			cs_rd_q <= cs_mem[cs_rd_addr];
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = out_value_q;
	assign status    = out_status_q;

endmodule

@@ design/csc_sparse_matrix_store_unit.sv @@
// Channel   Handshake                Payload
// input     in_valid / in_ready      op, value, row, col
// result    out_valid / out_ready    value_out, status
// config    psel, penable, pwrite    paddr, pwdata, prdata (pready tied high)
//
// From acceptance to a valid result: a clear, a zero scan element or an error finishes in the execute state;
// a load fills one column-start entry per column it moves ahead, then commits.
// A lookup reads its column's start and end, then walks the stored entries of its column up to the match.
// The column-start and entry stores each have one read port, which sets the walk rate.
// Reset empties the matrix at once; the stores need no clearing pass.
// A held result stalls only the back end; the two-entry queue keeps taking items until it is full.
module csc_sparse_matrix_store_unit #(
	parameter int MAX_ENTRIES = 1024,
	parameter int MAX_DIM = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [csc_pkg::OP_W-1:0]                op,
	input  logic signed [csc_pkg::VALUE_PORT_W-1:0] value,
	input  logic [csc_pkg::COORD_W-1:0]             row,
	input  logic [csc_pkg::COORD_W-1:0]             col,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [csc_pkg::VALUE_PORT_W-1:0] value_out,
	output logic [csc_pkg::STATUS_W-1:0]            status,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [csc_pkg::APB_ADDR_W-1:0]          paddr,
	input  logic [csc_pkg::APB_DATA_W-1:0]          pwdata,
	output logic [csc_pkg::APB_DATA_W-1:0]          prdata,
	output logic                                    pready
);
	import csc_pkg::*;

	localparam int DIM_DEPTH = (MAX_DIM < REG_DIM_MAX) ? MAX_DIM : REG_DIM_MAX;
	localparam int VAL_W     = (VALUE_WIDTH < VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;
	localparam int DIM_W     = $clog2(DIM_DEPTH + 1);
	localparam int IDX_W     = $clog2(DIM_DEPTH);
	localparam int DATA_W    = VAL_W + 2 * IDX_W;

	logic [CFG_W-1:0] num_rows_q;
	logic [CFG_W-1:0] num_cols_q;
	logic             cfg_wr;
	logic [DIM_W-1:0] rows;
	logic [DIM_W-1:0] cols;

	logic              push;
	cmd_ctl_t          push_ctl;
	logic [DATA_W-1:0] push_data;
	logic              q_full;
	logic              pop;
	logic              head_valid;
	cmd_ctl_t          head_ctl;
	logic [DATA_W-1:0] head_data;

	// Register port: always ready, written in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= CFG_W'(1);
			num_cols_q <= CFG_W'(1);
		end else if (cfg_wr) begin
			if (paddr[2] == REG_NUM_COLS) begin
				num_cols_q <= pwdata[CFG_W-1:0];
			end else begin
				num_rows_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_NUM_ROWS) ? APB_DATA_W'(num_rows_q) : APB_DATA_W'(num_cols_q);

	// Dimensions in use, limited to what the stores can hold.
	assign rows = (num_rows_q > CFG_W'(DIM_DEPTH)) ? DIM_W'(DIM_DEPTH) : DIM_W'(num_rows_q);
	assign cols = (num_cols_q > CFG_W'(DIM_DEPTH)) ? DIM_W'(DIM_DEPTH) : DIM_W'(num_cols_q);

	csc_front #(
		.DIM_DEPTH (DIM_DEPTH),
		.VAL_W     (VAL_W)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.value     (value),
		.row       (row),
		.col       (col),
		.rows      (rows),
		.cols      (cols),
		.q_full    (q_full),
		.push      (push),
		.push_ctl  (push_ctl),
		.push_data (push_data)
	);

	csc_cmd_fifo #(
		.DATA_W (DATA_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_ctl   (head_ctl),
		.head_data  (head_data)
	);

	csc_back #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.DIM_DEPTH   (DIM_DEPTH),
		.VAL_W       (VAL_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rows       (rows),
		.cols       (cols),
		.head_valid (head_valid),
		.head_ctl   (head_ctl),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value_out  (value_out),
		.status     (status)
	);

endmodule
